@@ src/sha_pkg.sv @@
package sha_pkg;

  // Byte source for the absorb path
  localparam logic [1:0] SEL_INPUT = 2'd0;
  localparam logic [1:0] SEL_PAD80 = 2'd1;
  localparam logic [1:0] SEL_ZERO  = 2'd2;
  localparam logic [1:0] SEL_LEN   = 2'd3;

  localparam logic [7:0] PAD_BYTE     = 8'h80;
  localparam logic [5:0] FILL_LEN_POS = 6'd56;
  localparam logic [5:0] FILL_LAST    = 6'd63;
  localparam logic [5:0] ROUND_LAST   = 6'd63;
  localparam logic [3:0] LEN_BYTES    = 4'd8;
  localparam logic [2:0] IDX_LAST_224 = 3'd6;
  localparam logic [2:0] IDX_LAST_256 = 3'd7;

  // Commands from controller to datapath
  typedef struct packed {
    logic       start;     // message start: load initial values, restart fill
    logic       absorb;    // take one byte into the block
    logic [1:0] byte_sel;
    logic [2:0] len_idx;
    logic       count;     // count a message byte
    logic       init;      // copy chaining value into working variables
    logic       round;     // run one compression round
    logic [5:0] rnd;
    logic       add;       // fold working variables into chaining value
    logic       clear;     // end of message
    logic [2:0] word_sel;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [5:0] fill;
    logic       msg_zero;
    logic       over;
    logic       mode;
  } dp_status_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_value(input logic mode, input logic [2:0] i);
    logic [31:0] v;
    if (mode) begin
      case (i)
        3'd0: v = 32'h6a09e667; 3'd1: v = 32'hbb67ae85;
        3'd2: v = 32'h3c6ef372; 3'd3: v = 32'ha54ff53a;
        3'd4: v = 32'h510e527f; 3'd5: v = 32'h9b05688c;
        3'd6: v = 32'h1f83d9ab; default: v = 32'h5be0cd19;
      endcase
    end else begin
      case (i)
        3'd0: v = 32'hc1059ed8; 3'd1: v = 32'h367cd507;
        3'd2: v = 32'h3070dd17; 3'd3: v = 32'hf70e5939;
        3'd4: v = 32'hffc00b31; 3'd5: v = 32'h68581511;
        3'd6: v = 32'h64f98fa7; default: v = 32'hbefa4fa4;
      endcase
    end
    return v;
  endfunction

endpackage

@@ src/sha_if.sv @@
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;
  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  logic        length_error;
  modport source (output valid, digest_word, word_index, last_word, length_error,
                  input ready);
  modport sink (input valid, digest_word, word_index, last_word, length_error,
                output ready);
endinterface

interface sha_cfg_if;
  logic valid;
  logic ready;
  logic hash_mode;
  modport source (output valid, hash_mode, input ready);
  modport sink (input valid, hash_mode, output ready);
endinterface

@@ src/sha224_sha256_hash.sv @@
// Channel   Dir  Payload                                           Handshake
// in_ch     in   data_byte, byte_present, end_of_message           valid/ready
// out_ch    out  digest_word, word_index, last_word, length_error  valid/ready
// cfg_ch    in   hash_mode                                         valid/ready
//
// A byte request is taken while idle; the 64th byte of a block then starts
// the load, 64 rounds on the single round unit and fold. The final request
// pads one byte a cycle, compresses one or two blocks and then presents
// 7 or 8 words (one error word if over-long), one per accepted output cycle.
// rst_n is synchronous; after it the mode is SHA-256 and no message is open.
// in_ch is ready only while idle; an output stall holds the digest word.
module sha224_sha256_hash (
  input logic      clk,
  input logic      rst_n,
  sha_in_if.sink   in_ch,
  sha_out_if.source out_ch,
  sha_cfg_if.sink  cfg_ch
);

  sha_pkg::dp_cmd_t    cmd;
  sha_pkg::dp_status_t status;
  logic [31:0]         word;
  logic                out_err;
  logic                out_last;

  assign cfg_ch.ready = 1'b1;

  sha_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_present (in_ch.byte_present),
    .in_end     (in_ch.end_of_message),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_last   (out_last),
    .out_err    (out_err),
    .status     (status),
    .cmd        (cmd)
  );

  sha_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_byte  (in_ch.data_byte),
    .cfg_we   (cfg_ch.valid),
    .cfg_mode (cfg_ch.hash_mode),
    .status   (status),
    .word     (word)
  );

  // Zero the word on the error request
  assign out_ch.digest_word  = out_err ? 32'd0 : word;
  assign out_ch.word_index   = out_err ? 3'd0 : cmd.word_sel;
  assign out_ch.last_word    = out_last;
  assign out_ch.length_error = out_err;

endmodule

@@ src/sha_dp.sv @@
module sha_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha_pkg::dp_cmd_t     cmd,
  input  logic [7:0]           in_byte,
  input  logic                 cfg_we,
  input  logic                 cfg_mode,
  output sha_pkg::dp_status_t  status,
  output logic [31:0]          word
);

  logic        mode_r, mode_nxt;
  logic [32:0] msg_r, msg_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [31:0] cv_r [8];
  logic [31:0] cv_nxt [8];
  logic [31:0] wv_r [8];
  logic [31:0] wv_nxt [8];

  logic [5:0]  fill_eff;
  logic [7:0]  abs_byte;
  logic [63:0] len_bits;
  logic [31:0] sched_new, t1, t2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Pick the byte to absorb
  assign len_bits = {29'd0, msg_r[31:0], 3'd0};
  always_comb begin
    case (cmd.byte_sel)
      sha_pkg::SEL_INPUT: abs_byte = in_byte;
      sha_pkg::SEL_PAD80: abs_byte = sha_pkg::PAD_BYTE;
      sha_pkg::SEL_ZERO:  abs_byte = 8'd0;
      default:            abs_byte = len_bits[8 * (7 - cmd.len_idx) +: 8];
    endcase
  end

  assign fill_eff = cmd.start ? 6'd0 : fill_r;

  // Schedule expansion and round function
  assign sched_new = (rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10))
                   + w_r[9]
                   + (rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3))
                   + w_r[0];
  assign t1 = wv_r[7]
            + (rotr(wv_r[4], 6) ^ rotr(wv_r[4], 11) ^ rotr(wv_r[4], 25))
            + ((wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]))
            + sha_pkg::round_k(cmd.rnd) + w_r[0];
  assign t2 = (rotr(wv_r[0], 2) ^ rotr(wv_r[0], 13) ^ rotr(wv_r[0], 22))
            + ((wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]));

  always_comb begin
    mode_nxt = cfg_we ? cfg_mode : mode_r;
    msg_nxt  = msg_r;
    fill_nxt = fill_eff;
    acc_nxt  = acc_r;
    w_nxt    = w_r;
    cv_nxt   = cv_r;
    wv_nxt   = wv_r;
    // load initial values at message start
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) cv_nxt[i] = sha_pkg::init_value(mode_r, 3'(i));
    end
    // count message bytes, saturating past the limit
    if (cmd.count && !msg_r[32]) msg_nxt = msg_r + 33'd1;
    // pack bytes big-endian and shift whole words into the window
    if (cmd.absorb) begin
      acc_nxt  = {acc_r[23:0], abs_byte};
      fill_nxt = fill_eff + 6'd1;
      if (fill_eff[1:0] == 2'd3) begin
        for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i + 1];
        w_nxt[15] = acc_nxt;
      end
    end
    if (cmd.init) wv_nxt = cv_r;
    // one round: consume w[0], append the next schedule word
    if (cmd.round) begin
      for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i + 1];
      w_nxt[15] = sched_new;
      for (int i = 7; i > 0; i--) wv_nxt[i] = wv_r[i - 1];
      wv_nxt[0] = t1 + t2;
      wv_nxt[4] = wv_r[3] + t1;
    end
    if (cmd.add) begin
      for (int i = 0; i < 8; i++) cv_nxt[i] = cv_r[i] + wv_r[i];
    end
    if (cmd.clear) begin
      msg_nxt  = 33'd0;
      fill_nxt = 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
      msg_r  <= 33'd0;
      fill_r <= 6'd0;
    end else begin
      mode_r <= mode_nxt;
      msg_r  <= msg_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    w_r   <= w_nxt;
    cv_r  <= cv_nxt;
    wv_r  <= wv_nxt;
  end

  assign status.fill     = fill_r;
  assign status.msg_zero = (msg_r == 33'd0);
  assign status.over     = msg_r[32];
  assign status.mode     = mode_r;
  assign word            = cv_r[cmd.word_sel];

endmodule

@@ src/sha_ctrl.sv @@
module sha_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_present,
  input  logic                 in_end,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_last,
  output logic                 out_err,
  input  sha_pkg::dp_status_t  status,
  output sha_pkg::dp_cmd_t     cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_PAD   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic       fin_r, fin_nxt;
  logic       pad_r, pad_nxt;
  logic       sent_r, sent_nxt;
  logic [3:0] len_r, len_nxt;
  logic [2:0] idx_r, idx_nxt;

  logic       accept;
  logic [5:0] fill_eff;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign fill_eff  = status.msg_zero ? 6'd0 : status.fill;
  assign out_valid = (state_r == S_OUT);
  assign out_err   = status.over;
  assign out_last  = status.over ||
                     (idx_r == (status.mode ? sha_pkg::IDX_LAST_256 : sha_pkg::IDX_LAST_224));

  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    fin_nxt   = fin_r;
    pad_nxt   = pad_r;
    sent_nxt  = sent_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.rnd      = rnd_r;
    cmd.word_sel = idx_r;
    cmd.len_idx  = len_r[2:0];
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.start    = status.msg_zero;
          cmd.absorb   = in_present;
          cmd.count    = in_present;
          cmd.byte_sel = sha_pkg::SEL_INPUT;
          fin_nxt      = in_end;
          pad_nxt      = 1'b0;
          if (in_present && fill_eff == sha_pkg::FILL_LAST) begin
            state_nxt = S_INIT;
          end else if (in_end) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        rnd_nxt   = 6'd0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == sha_pkg::ROUND_LAST) state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        if (pad_r) begin
          state_nxt = (len_r == sha_pkg::LEN_BYTES) ? S_OUT : S_PAD;
        end else begin
          state_nxt = fin_r ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        // over-long message skips padding and reports once
        sent_nxt  = 1'b0;
        len_nxt   = 4'd0;
        idx_nxt   = 3'd0;
        pad_nxt   = !status.over;
        state_nxt = status.over ? S_OUT : S_PAD;
      end
      S_PAD: begin
        cmd.absorb = 1'b1;
        if (!sent_r) begin
          cmd.byte_sel = sha_pkg::SEL_PAD80;
          sent_nxt     = 1'b1;
        end else if (len_r == 4'd0 && status.fill != sha_pkg::FILL_LEN_POS) begin
          cmd.byte_sel = sha_pkg::SEL_ZERO;
        end else begin
          cmd.byte_sel = sha_pkg::SEL_LEN;
          len_nxt      = len_r + 4'd1;
        end
        if (status.fill == sha_pkg::FILL_LAST) state_nxt = S_INIT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (out_last) begin
            cmd.clear = 1'b1;
            idx_nxt   = 3'd0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rnd_r   <= 6'd0;
      fin_r   <= 1'b0;
      pad_r   <= 1'b0;
      sent_r  <= 1'b0;
      len_r   <= 4'd0;
      idx_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      fin_r   <= fin_nxt;
      pad_r   <= pad_nxt;
      sent_r  <= sent_nxt;
      len_r   <= len_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

@@ verif/sha_digest_checker.sv @@
module sha_digest_checker (
  input logic clk,
  input logic rst_n,
  sha_in_if.sink in_mon,
  sha_out_if.sink out_mon,
  sha_cfg_if.sink cfg_mon,
  output int unsigned fail_count,
  output int unsigned pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
    logic        err;
  } digest_word_t;

  localparam logic [32:0] BYTE_CAP = 33'h0_ffff_ffff;

  digest_word_t digest_q[$];
  logic        mode_q;
  logic [31:0] chain[8];
  logic [31:0] sched[16];
  logic [5:0]  fill;
  logic [32:0] nbytes;

  function automatic logic [31:0] rr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // run 64 rounds on the current block and fold into the chaining value
  task automatic compress_block();
    logic [31:0] v[8];
    logic [31:0] w, x15, x2, t1, t2;
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        w = sched[t];
      end else begin
        x15 = sched[(t - 15) & 15];
        x2 = sched[(t - 2) & 15];
        w = sched[t & 15] + (rr(x15, 7) ^ rr(x15, 18) ^ (x15 >> 3)) + sched[(t - 7) & 15]
            + (rr(x2, 17) ^ rr(x2, 19) ^ (x2 >> 10));
        sched[t & 15] = w;
      end
      t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::round_k(t[5:0]) + w;
      t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i - 1];
      v[0] = t1 + t2;
      v[4] = v[4] + t1;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endtask

  task automatic take_byte(logic [7:0] b);
    int sh;
    sh = 24 - 8 * fill[1:0];
    if (fill[1:0] == 2'd0) sched[fill[5:2]] = 32'(b) << sh;
    else sched[fill[5:2]] = sched[fill[5:2]] | (32'(b) << sh);
    if (fill == sha_pkg::FILL_LAST) begin
      compress_block();
      fill = '0;
    end else begin
      fill = fill + 6'd1;
    end
  endtask

  // predict the digest words caused by one request
  task automatic predict_request(logic [7:0] b, logic present, logic eom);
    logic [63:0] bits;
    digest_word_t r;
    int n;
    if (nbytes == '0) begin
      for (int i = 0; i < 8; i++) chain[i] = sha_pkg::init_value(mode_q, i[2:0]);
      fill = '0;
    end
    if (present) begin
      take_byte(b);
      if (nbytes <= BYTE_CAP) nbytes = nbytes + 33'd1;
    end
    if (!eom) return;
    if (nbytes > BYTE_CAP) begin
      r = '{32'd0, 3'd0, 1'b1, 1'b1};
      digest_q.push_back(r);
    end else begin
      bits = 64'(nbytes) << 3;
      take_byte(sha_pkg::PAD_BYTE);
      while (fill != sha_pkg::FILL_LEN_POS) take_byte(8'h00);
      for (int i = 0; i < 8; i++) take_byte(bits[63 - 8 * i -: 8]);
      n = mode_q ? 8 : 7;
      for (int i = 0; i < n; i++) begin
        r = '{chain[i], i[2:0], (i == n - 1), 1'b0};
        digest_q.push_back(r);
      end
    end
    nbytes = '0;
    fill = '0;
  endtask

  assign pending_words = digest_q.size();

  always @(posedge clk) begin
    digest_word_t e;
    if (!rst_n) begin
      mode_q <= 1'b1;
      nbytes = '0;
      fill = '0;
      digest_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) mode_q <= cfg_mon.hash_mode;
      if (in_mon.valid && in_mon.ready)
        predict_request(in_mon.data_byte, in_mon.byte_present, in_mon.end_of_message);
      // compare each accepted word with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual %h idx %0d last %b err %b",
                   $time, out_mon.digest_word, out_mon.word_index, out_mon.last_word,
                   out_mon.length_error);
          fail_count <= fail_count + 1;
        end else begin
          e = digest_q.pop_front();
          if (e.word !== out_mon.digest_word || e.idx !== out_mon.word_index ||
              e.last !== out_mon.last_word || e.err !== out_mon.length_error) begin
            $display("%0t: word mismatch: expected %h idx %0d last %b err %b, actual %h idx %0d last %b err %b",
                     $time, e.word, e.idx, e.last, e.err, out_mon.digest_word,
                     out_mon.word_index, out_mon.last_word, out_mon.length_error);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ verif/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  int unsigned fail_count;
  int unsigned pending_words;
  int unsigned cycle_count;
  bit hold_req;
  bit hold_taken;
  int unsigned sent;

  sha_in_if  in_ch();
  sha_out_if out_ch();
  sha_cfg_if cfg_ch();

  sha224_sha256_hash dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                          .cfg_ch(cfg_ch));

  sha_digest_checker checker_i (.clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
                                .cfg_mon(cfg_ch), .fail_count(fail_count),
                                .pending_words(pending_words));

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one request and hold it until taken
  task automatic send_request(logic [7:0] b, logic present, logic eom);
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.byte_present <= present;
    in_ch.end_of_message <= eom;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic idle_gap(int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // drain: wait until every predicted word has come, then let the block settle
  task automatic drain();
    idle_gap(1);
    while (pending_words != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // let the block go quiet before touching the mode
  task automatic write_mode(logic m);
    idle_gap(1);
    while (pending_words != 0) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.hash_mode <= m;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // one message of random bytes, sent in bursts
  task automatic send_message(int len, bit empty_end);
    int burst;
    burst = $urandom_range(1, 20);
    for (int i = 0; i < len; i++) begin
      if (burst == 0) begin
        idle_gap($urandom_range(1, 6));
        burst = $urandom_range(1, 20);
      end
      burst--;
      if ($urandom_range(0, 15) == 0) send_request(8'($urandom), 1'b0, 1'b0);
      send_request(8'($urandom), 1'b1, (i == len - 1) && !empty_end);
    end
    if (empty_end || len == 0) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  // receiver stalls in a pattern, with one long hold-off counted here
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    hold_taken = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = 300;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end
      else if (cycle_count % 400 < 150) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int lens[5];
    hold_req = 1'b0;
    sent = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.byte_present = 1'b0;
    in_ch.end_of_message = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.hash_mode = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: empty message, extreme bytes, idle item, both modes
    send_request(8'hff, 1'b0, 1'b1);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'hff, 1'b1, 1'b0);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'haa, 1'b1, 1'b0);
    send_request(8'h55, 1'b1, 1'b1);
    drain();
    write_mode(1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'h80, 1'b1, 1'b1);
    send_request(8'h7f, 1'b1, 1'b0);
    // change mode mid-message: digest length follows the new mode
    drain();
    write_mode(1'b1);
    send_request(8'h01, 1'b1, 1'b1);
    drain();
    // random messages around block boundaries, mode changed between them
    lens = '{55, 56, 63, 64, 119};
    while (sent < 430) begin
      write_mode(1'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0)
        send_message(lens[$urandom_range(0, 4)], 1'($urandom_range(0, 1)));
      else send_message($urandom_range(0, 12), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 4) == 0) drain();
      if (!hold_req && sent > 200) begin
        // long receiver hold-off while three more messages are offered
        hold_req = 1'b1;
        send_message(3, 1'b0);
        send_message(2, 1'b0);
        send_message(4, 1'b1);
      end
    end
    drain();
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

@@ filelist.f @@
src/sha_pkg.sv
src/sha_if.sv
src/sha_dp.sv
src/sha_ctrl.sv
src/sha224_sha256_hash.sv
verif/sha_digest_checker.sv
verif/tb.sv
